// ----- rtl/bnf_pkg.sv -----
// Shared constants and types for the biquad notch filter.
`default_nettype none

package bnf_pkg;

   // coefficient and state widths
   localparam int COEF_W  = 32;
   localparam int STATE_W = 52;

   // feedback operand y is split into an unsigned low half and a signed high half
   localparam int YL_W = STATE_W / 2;
   localparam int YH_W = STATE_W - YL_W;
   localparam int MB_W = YL_W + 1;
   localparam int PROD_W = COEF_W + MB_W;

   // register map
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_B0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_B1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_A1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_A2 = 3'd4;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_Y     = 10'b00_0000_0010,
      ST_LOAD1 = 10'b00_0000_0100,
      ST_A1L   = 10'b00_0000_1000,
      ST_A1H   = 10'b00_0001_0000,
      ST_B2    = 10'b00_0010_0000,
      ST_LOAD2 = 10'b00_0100_0000,
      ST_A2H   = 10'b00_1000_0000,
      ST_FIN   = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/biquad_notch_filter.sv -----
// Biquad IIR filter (transposed direct form II) around one shared multiply-accumulate.
//
// Usage:
//  - req_* beats carry one signed sample and an end-of-buffer mark; rsp_* beats
//    carry the filtered sample and the copied mark. A beat moves when valid is
//    high and stall is low.
//  - Coefficients b0, b1, b2, a1, a2 (signed, COEF_FRAC_BITS fraction bits) are
//    written through csr_wr_en/csr_index/csr_wdata while the filter is idle.
//    Any coefficient write clears both delay elements.
//  - One 32x27 multiplier and one accumulator compute the seven products of a
//    sample in sequence (b0*x, b1*x, a1*y as two halves, b2*x, a2*y as two halves).
//    That sequencer sets the rate: a new sample is taken only once the last one has
//    left the last step, and rsp_valid is registered as the sequencer leaves it.
//  - req_stall stays high while a sample is being processed.
//  - The result sits in an output register; the next request is taken while it
//    waits. If rsp_stall holds that register occupied when the next sample is
//    finished, the sequencer waits in its last step.
//  - Reset (synchronous) restores b0 = 1.0, the other coefficients to zero,
//    clears the delays and drops rsp_valid.
`default_nettype none

module biquad_notch_filter #(
   parameter int COEF_FRAC_BITS = 30,
   parameter int SAMPLE_WIDTH   = 16
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_stall,
   input  wire  signed [SAMPLE_WIDTH-1:0]           req_sample_in,
   input  wire                                      req_last_in,
   output logic                                     rsp_valid,
   input  wire                                      rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]           rsp_sample_out,
   output logic                                     rsp_last_out,
   input  wire                                      csr_wr_en,
   input  wire         [bnf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire         [bnf_pkg::COEF_W-1:0]        csr_wdata
);

   localparam int F       = COEF_FRAC_BITS;
   localparam int COEF_W  = bnf_pkg::COEF_W;
   localparam int STATE_W = bnf_pkg::STATE_W;
   localparam int YL_W    = bnf_pkg::YL_W;
   localparam int YH_W    = bnf_pkg::YH_W;
   localparam int MB_W    = bnf_pkg::MB_W;
   localparam int PROD_W  = bnf_pkg::PROD_W;
   // accumulator holds values scaled by 2^F
   localparam int PX_W    = COEF_W + SAMPLE_WIDTH + F;
   localparam int PY_W    = COEF_W + STATE_W;
   localparam int ACC_W   = ((PX_W > PY_W) ? PX_W : PY_W) + 2;
   localparam int T_W     = ACC_W - F;
   // unscaled y = b0*x + d1
   localparam int YR_W    = ((COEF_W + SAMPLE_WIDTH > STATE_W) ?
                             (COEF_W + SAMPLE_WIDTH) : STATE_W) + 1;
   localparam int RW_W    = YR_W + 1 - F;

   localparam logic signed [COEF_W-1:0] B0_RESET =
      {{(COEF_W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
   localparam logic [YR_W:0] HALF    = {{(YR_W+1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
   localparam logic [YR_W:0] HALF_M1 = {{(YR_W+2-F){1'b0}}, {(F-1){1'b1}}};

   bnf_pkg::state_type state_ff, state_in;

   logic signed [COEF_W-1:0]       coef_b0_ff, coef_b1_ff, coef_b2_ff, coef_a1_ff, coef_a2_ff;
   logic signed [STATE_W-1:0]      d1_ff, d1_in, d2_ff, d2_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic                           last_ff;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [YR_W-1:0]         y_ff;
   logic signed [STATE_W-1:0]      yf_ff, yf_in;
   logic signed [SAMPLE_WIDTH-1:0] round_ff, round_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff;
   logic                           rsp_last_ff;

   logic                           req_take, done_go, csr_hit;
   logic signed [COEF_W-1:0]       mult_a;
   logic signed [MB_W-1:0]         mult_b;
   logic signed [MB_W-1:0]         x_req_ext, x_ext, ylo_ext, yhi_ext;
   logic signed [ACC_W-1:0]        acc_base, acc_term, prod_ext;
   logic                           acc_sub;
   logic signed [T_W-1:0]          acc_top;
   logic signed [STATE_W-1:0]      acc_sat;
   logic [YR_W:0]                  rnd_sum;
   logic [RW_W-1:0]                rnd_wide;

   assign req_stall      = (state_ff != bnf_pkg::ST_IDLE);
   assign req_take       = req_valid && !req_stall;
   assign done_go        = (state_ff == bnf_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_last_out   = rsp_last_ff;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bnf_pkg::ST_IDLE:  if (req_valid) state_in = bnf_pkg::ST_Y;
         bnf_pkg::ST_Y:     state_in = bnf_pkg::ST_LOAD1;
         bnf_pkg::ST_LOAD1: state_in = bnf_pkg::ST_A1L;
         bnf_pkg::ST_A1L:   state_in = bnf_pkg::ST_A1H;
         bnf_pkg::ST_A1H:   state_in = bnf_pkg::ST_B2;
         bnf_pkg::ST_B2:    state_in = bnf_pkg::ST_LOAD2;
         bnf_pkg::ST_LOAD2: state_in = bnf_pkg::ST_A2H;
         bnf_pkg::ST_A2H:   state_in = bnf_pkg::ST_FIN;
         bnf_pkg::ST_FIN:   state_in = bnf_pkg::ST_DONE;
         bnf_pkg::ST_DONE:  if (done_go) state_in = bnf_pkg::ST_IDLE;
         default:           state_in = bnf_pkg::ST_IDLE;
      endcase
   end

   // ---------------- shared multiplier ----------------
   assign x_req_ext = {{(MB_W-SAMPLE_WIDTH){req_sample_in[SAMPLE_WIDTH-1]}}, req_sample_in};
   assign x_ext     = {{(MB_W-SAMPLE_WIDTH){sample_ff[SAMPLE_WIDTH-1]}}, sample_ff};
   assign ylo_ext   = {1'b0, yf_ff[YL_W-1:0]};
   assign yhi_ext   = {{(MB_W-YH_W){yf_ff[STATE_W-1]}}, yf_ff[STATE_W-1:YL_W]};

   always_comb begin
      mult_a = coef_b0_ff;
      mult_b = x_req_ext;
      unique case (state_ff)
         bnf_pkg::ST_Y:     begin mult_a = coef_b1_ff; mult_b = x_ext;   end
         bnf_pkg::ST_A1L:   begin mult_a = coef_a1_ff; mult_b = ylo_ext; end
         bnf_pkg::ST_A1H:   begin mult_a = coef_a1_ff; mult_b = yhi_ext; end
         bnf_pkg::ST_B2:    begin mult_a = coef_b2_ff; mult_b = x_ext;   end
         bnf_pkg::ST_LOAD2: begin mult_a = coef_a2_ff; mult_b = ylo_ext; end
         bnf_pkg::ST_A2H:   begin mult_a = coef_a2_ff; mult_b = yhi_ext; end
         default: ;
      endcase
   end

   assign prod_in = PROD_W'(mult_a) * PROD_W'(mult_b);

   // ---------------- accumulator ----------------
   // delay terms: t = floor(((b*x + d)*2^F + 2^F - 1 - a*y) / 2^F)
   //            = b*x + d - floor(a*y / 2^F)
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      acc_base = acc_ff;
      acc_term = '0;
      acc_sub  = 1'b0;
      unique case (state_ff) inside
         bnf_pkg::ST_IDLE: begin
            acc_base = {{(ACC_W-STATE_W-F){d1_ff[STATE_W-1]}}, d1_ff, {F{1'b0}}};
         end
         bnf_pkg::ST_Y: begin
            acc_term = prod_ext <<< F;
         end
         bnf_pkg::ST_LOAD1: begin
            acc_base = {{(ACC_W-STATE_W-F){d2_ff[STATE_W-1]}}, d2_ff, {F{1'b1}}};
            acc_term = prod_ext <<< F;
         end
         bnf_pkg::ST_A1H, bnf_pkg::ST_A2H: begin
            acc_term = prod_ext;
            acc_sub  = 1'b1;
         end
         bnf_pkg::ST_B2, bnf_pkg::ST_FIN: begin
            acc_term = prod_ext <<< YL_W;
            acc_sub  = 1'b1;
         end
         bnf_pkg::ST_LOAD2: begin
            acc_base = {{(ACC_W-F){1'b0}}, {F{1'b1}}};
            acc_term = prod_ext <<< F;
         end
         default: ;
      endcase
      acc_in = acc_sub ? (acc_base - acc_term) : (acc_base + acc_term);
   end

   // delay saturation to the state width
   assign acc_top = acc_ff[ACC_W-1:F];

   always_comb begin
      if ((&acc_top[T_W-1:STATE_W-1]) || !(|acc_top[T_W-1:STATE_W-1])) begin
         acc_sat = acc_top[STATE_W-1:0];
      end else if (acc_top[T_W-1]) begin
         acc_sat = {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         acc_sat = {1'b0, {(STATE_W-1){1'b1}}};
      end
   end

   // feedback operand: y clamped to the state width
   always_comb begin
      if ((&y_ff[YR_W-1:STATE_W-1]) || !(|y_ff[YR_W-1:STATE_W-1])) begin
         yf_in = y_ff[STATE_W-1:0];
      end else if (y_ff[YR_W-1]) begin
         yf_in = {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         yf_in = {1'b0, {(STATE_W-1){1'b1}}};
      end
   end

   // round half away from zero: (y + half - (y < 0)) >>> F, then saturate
   assign rnd_sum  = {y_ff[YR_W-1], y_ff} + (y_ff[YR_W-1] ? HALF_M1 : HALF);
   assign rnd_wide = rnd_sum[YR_W:F];

   always_comb begin
      if ((&rnd_wide[RW_W-1:SAMPLE_WIDTH-1]) || !(|rnd_wide[RW_W-1:SAMPLE_WIDTH-1])) begin
         round_in = rnd_wide[SAMPLE_WIDTH-1:0];
      end else if (rnd_wide[RW_W-1]) begin
         round_in = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         round_in = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end
   end

   // ---------------- delay elements ----------------
   always_comb begin
      unique case (csr_index) inside
         bnf_pkg::CSR_B0, bnf_pkg::CSR_B1, bnf_pkg::CSR_B2,
         bnf_pkg::CSR_A1, bnf_pkg::CSR_A2: csr_hit = csr_wr_en;
         default:                          csr_hit = 1'b0;
      endcase
   end

   always_comb begin
      d1_in = d1_ff;
      d2_in = d2_ff;
      if (csr_hit) begin
         d1_in = '0;
         d2_in = '0;
      end else if (state_ff == bnf_pkg::ST_LOAD2) begin
         d1_in = acc_sat;
      end else if (done_go) begin
         d2_in = acc_sat;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bnf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         d1_ff        <= '0;
         d2_ff        <= '0;
         coef_b0_ff   <= B0_RESET;
         coef_b1_ff   <= '0;
         coef_b2_ff   <= '0;
         coef_a1_ff   <= '0;
         coef_a2_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         d1_ff        <= d1_in;
         d2_ff        <= d2_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               bnf_pkg::CSR_B0: coef_b0_ff <= csr_wdata;
               bnf_pkg::CSR_B1: coef_b1_ff <= csr_wdata;
               bnf_pkg::CSR_B2: coef_b2_ff <= csr_wdata;
               bnf_pkg::CSR_A1: coef_a1_ff <= csr_wdata;
               bnf_pkg::CSR_A2: coef_a2_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (req_take) begin
         sample_ff <= req_sample_in;
         last_ff   <= req_last_in;
      end
      if (state_ff == bnf_pkg::ST_Y) begin
         y_ff <= acc_in[F +: YR_W];
      end
      if (state_ff == bnf_pkg::ST_LOAD1) begin
         yf_ff    <= yf_in;
         round_ff <= round_in;
      end
      if (done_go) begin
         rsp_sample_ff <= round_ff;
         rsp_last_ff   <= last_ff;
      end
   end

`ifndef SYNTH
   // a result beat only appears at the end of the sequence
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bnf_pkg::ST_DONE))
      else $error("rsp_valid rose outside the final step");

   // an accepted beat starts the sequence and blocks further requests
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == bnf_pkg::ST_Y) && req_stall)
      else $error("accepted request did not start the sequence");

   // a coefficient write clears both delays
   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      (csr_wr_en && (csr_index == bnf_pkg::CSR_B0 || csr_index == bnf_pkg::CSR_B1 ||
                     csr_index == bnf_pkg::CSR_B2 || csr_index == bnf_pkg::CSR_A1 ||
                     csr_index == bnf_pkg::CSR_A2))
      |=> (d1_ff == '0) && (d2_ff == '0))
      else $error("delays not cleared after coefficient write");
`endif

endmodule

`default_nettype wire
